// ===== sv/obd_pkg.sv =====
package obd_pkg;

   localparam int LINE_CHARS = 256;
   localparam int HEX_DIGITS = 128;
   localparam int VIN_LEN    = 17;

   localparam int LEN_W      = $clog2(LINE_CHARS);
   localparam int DIG_W      = $clog2(HEX_DIGITS);
   localparam int LINE_SLOTS = HEX_DIGITS / 2;
   localparam int SLOT_W     = $clog2(LINE_SLOTS);
   localparam int VIN_W      = $clog2(VIN_LEN + 1);
   localparam int VIN_AW     = $clog2(VIN_LEN);

   localparam int BYTE_W     = 8;
   localparam int KIND_W     = 3;
   localparam int VALUE_W    = 15;
   localparam int ACTION_W   = 2;
   localparam int MIN_DIGITS = 4;

   // throttle: floor(A * 10000 / 255) via reciprocal estimate plus one fix-up step
   localparam int THROTTLE_SCALE = 10000;
   localparam int THR_DIVISOR    = 255;
   localparam int THR_RECIP      = 257;
   localparam int THR_SHIFT      = 16;
   localparam int PROD_W         = BYTE_W + $clog2(THROTTLE_SCALE);
   localparam int EST_W          = PROD_W + $clog2(THR_RECIP);
   localparam int REM_W          = VALUE_W + BYTE_W;
   localparam int COOLANT_OFFSET = 40;

   localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_PROMPT = 8'h3E;

   localparam logic [BYTE_W-1:0] MODE09_RSP   = 8'h49;
   localparam logic [BYTE_W-1:0] PID_VIN      = 8'h02;
   localparam logic [BYTE_W-1:0] MODE01_RSP   = 8'h41;
   localparam logic [BYTE_W-1:0] PID_SPEED    = 8'h0D;
   localparam logic [BYTE_W-1:0] PID_RPM      = 8'h0C;
   localparam logic [BYTE_W-1:0] PID_THROTTLE = 8'h11;
   localparam logic [BYTE_W-1:0] PID_COOLANT  = 8'h05;

   typedef enum logic [ACTION_W-1:0] {
      ACT_BYTE     = 2'd0,
      ACT_DROP     = 2'd1,
      ACT_NEW_LINK = 2'd2
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_SPEED    = 3'd0,
      KIND_RPM      = 3'd1,
      KIND_THROTTLE = 3'd2,
      KIND_COOLANT  = 3'd3,
      KIND_VIN      = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_THR_MUL,
      ST_THR_EST,
      ST_THR_FIX,
      ST_PUT,
      ST_VIN_RD,
      ST_VIN_PUT
   } state_type;

   // bit 4 flags a hex digit, bits 3:0 hold its value
   function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

endpackage

// ===== sv/obd_response_line_decoder.sv =====
// channel  dir  tdata                                            tuser       tlast
// req_     in   [7:0] rx_byte                                    [1:0] action  -
// rsp_     out  [14:0] value, [19:15] vin_index, [27:20] vin_char [2:0] kind   last
//
// A received character, a drop or a new link is handled in the idle state as it is taken.
// A line end walks the stored byte pairs at one per cycle, then decides and loads a
// metric; throttle adds multiply, estimate and fix-up steps; a VIN is sent from its
// store, each character read and then put.
// The line memory has one read port, so the walk sets the cost of a line end.
// Synchronous reset empties the line and the VIN collector; no clearing pass.
// A stalled result holds the sequencer, and no input is taken while it waits.
module obd_response_line_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [14:0] value, [19:15] vin_index, [27:20] vin_char
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast
);

   localparam int BW = obd_pkg::BYTE_W;
   localparam int VW = obd_pkg::VALUE_W;

   obd_pkg::state_type state_ff, state_in;

   logic [obd_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [obd_pkg::DIG_W-1:0]  dig_ff, dig_in;
   logic [3:0]                 nib_ff, nib_in;
   logic [obd_pkg::SLOT_W-1:0] cnt_ff, cnt_in;
   logic [obd_pkg::SLOT_W-1:0] rdidx_ff, rdidx_in;
   logic [obd_pkg::SLOT_W-1:0] pidx_ff, pidx_in;
   logic                       pend_ff, pend_in;
   logic                       found_ff, found_in;
   logic [BW-1:0]              prev_ff, prev_in;
   logic [BW-1:0]              mb_ff [4];
   logic [BW-1:0]              mb_in [4];
   logic [obd_pkg::VIN_W-1:0]  vcnt_ff, vcnt_in;
   logic                       vdone_ff, vdone_in;
   logic [obd_pkg::VIN_AW-1:0] vk_ff, vk_in;
   logic [obd_pkg::PROD_W-1:0] acc_ff, acc_in;
   logic [VW-1:0]              q_ff, q_in;
   obd_pkg::kind_type          res_kind_ff, res_kind_in;
   logic signed [VW-1:0]       res_value_ff, res_value_in;

   logic                       out_valid_ff, out_valid_in;
   obd_pkg::kind_type          out_kind_ff, out_kind_in;
   logic signed [VW-1:0]       out_value_ff, out_value_in;
   logic [obd_pkg::VIN_AW-1:0] out_index_ff, out_index_in;
   logic [BW-1:0]              out_char_ff, out_char_in;
   logic                       out_last_ff, out_last_in;

   logic                       accept;
   logic                       out_free;
   logic [4:0]                 hd;
   logic [BW-1:0]              rx;
   logic                       is_term;
   logic                       line_we;
   logic                       vin_we;
   logic [BW-1:0]              line_rd;
   logic [BW-1:0]              vin_rd;
   logic [obd_pkg::EST_W-1:0]  est;
   logic [obd_pkg::REM_W-1:0]  rem;

   assign req_tready = (state_ff == obd_pkg::ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~out_valid_ff | rsp_tready;
   assign rx         = req_tdata;
   assign hd         = obd_pkg::hex_digit(rx);
   assign is_term    = (rx == obd_pkg::CHAR_CR) || (rx == obd_pkg::CHAR_LF) ||
                       (rx == obd_pkg::CHAR_PROMPT);

   obd_ram #(
      .WIDTH (BW),
      .DEPTH (obd_pkg::LINE_SLOTS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (dig_ff[obd_pkg::DIG_W-1:1]),
      .wr_data ({nib_ff, hd[3:0]}),
      .rd_addr (rdidx_ff),
      .rd_data (line_rd)
   );

   obd_ram #(
      .WIDTH (BW),
      .DEPTH (obd_pkg::VIN_LEN)
   ) u_vin_ram (
      .clock   (clock),
      .wr_en   (vin_we),
      .wr_addr (vcnt_ff[obd_pkg::VIN_AW-1:0]),
      .wr_data (line_rd),
      .rd_addr (vk_ff),
      .rd_data (vin_rd)
   );

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      dig_in       = dig_ff;
      nib_in       = nib_ff;
      cnt_in       = cnt_ff;
      rdidx_in     = rdidx_ff;
      pidx_in      = pidx_ff;
      pend_in      = pend_ff;
      found_in     = found_ff;
      prev_in      = prev_ff;
      mb_in        = mb_ff;
      vcnt_in      = vcnt_ff;
      vdone_in     = vdone_ff;
      vk_in        = vk_ff;
      acc_in       = acc_ff;
      q_in         = q_ff;
      res_kind_in  = res_kind_ff;
      res_value_in = res_value_ff;
      out_kind_in  = out_kind_ff;
      out_value_in = out_value_ff;
      out_index_in = out_index_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      line_we      = 1'b0;
      vin_we       = 1'b0;
      est          = '0;
      rem          = '0;
      out_valid_in = out_valid_ff & ~rsp_tready;

      case (state_ff)
         obd_pkg::ST_IDLE: begin
            if (accept) begin
               case (obd_pkg::action_type'(req_tuser))
                  obd_pkg::ACT_DROP: begin
                     len_in = '0;
                     dig_in = '0;
                  end
                  obd_pkg::ACT_NEW_LINK: begin
                     len_in   = '0;
                     dig_in   = '0;
                     vcnt_in  = '0;
                     vdone_in = 1'b0;
                  end
                  obd_pkg::ACT_BYTE: begin
                     if (is_term) begin
                        if (len_ff != '0) begin
                           len_in = '0;
                           dig_in = '0;
                           if (dig_ff >= obd_pkg::DIG_W'(obd_pkg::MIN_DIGITS) && !dig_ff[0]) begin
                              cnt_in   = dig_ff[obd_pkg::DIG_W-1:1];
                              rdidx_in = '0;
                              pend_in  = 1'b0;
                              found_in = 1'b0;
                              state_in = obd_pkg::ST_SCAN;
                           end
                        end
                     end else if (len_ff >= obd_pkg::LEN_W'(obd_pkg::LINE_CHARS - 1)) begin
                        // overlong line: restart empty
                        len_in = '0;
                        dig_in = '0;
                     end else begin
                        len_in = len_ff + 1'b1;
                        if (hd[4] && dig_ff < obd_pkg::DIG_W'(obd_pkg::HEX_DIGITS - 1)) begin
                           if (!dig_ff[0]) begin
                              nib_in = hd[3:0];
                           end else begin
                              line_we = 1'b1;
                           end
                           dig_in = dig_ff + 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         obd_pkg::ST_SCAN: begin
            // issue the next read while the previous byte is checked
            if (rdidx_ff < cnt_ff) begin
               pend_in  = 1'b1;
               pidx_in  = rdidx_ff;
               rdidx_in = rdidx_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (pidx_ff < obd_pkg::SLOT_W'(4)) begin
                  mb_in[pidx_ff[1:0]] = line_rd;
               end
               if (!found_ff) begin
                  if (pidx_ff != '0 && prev_ff == obd_pkg::MODE09_RSP &&
                      line_rd == obd_pkg::PID_VIN) begin
                     found_in = 1'b1;
                  end
               end else if (obd_pkg::is_alnum(line_rd) &&
                            vcnt_ff < obd_pkg::VIN_W'(obd_pkg::VIN_LEN)) begin
                  vin_we  = 1'b1;
                  vcnt_in = vcnt_ff + 1'b1;
               end
               prev_in = line_rd;
               if (pidx_ff == cnt_ff - 1'b1) begin
                  pend_in  = 1'b0;
                  state_in = obd_pkg::ST_DECIDE;
               end
            end
         end

         obd_pkg::ST_DECIDE: begin
            state_in = obd_pkg::ST_IDLE;
            if (found_ff) begin
               if (!vdone_ff && vcnt_ff == obd_pkg::VIN_W'(obd_pkg::VIN_LEN)) begin
                  vdone_in = 1'b1;
                  vk_in    = '0;
                  state_in = obd_pkg::ST_VIN_RD;
               end
            end else if (mb_ff[0] == obd_pkg::MODE01_RSP) begin
               case (mb_ff[1])
                  obd_pkg::PID_SPEED: begin
                     if (cnt_ff >= obd_pkg::SLOT_W'(3)) begin
                        res_kind_in  = obd_pkg::KIND_SPEED;
                        res_value_in = VW'(mb_ff[2]);
                        state_in     = obd_pkg::ST_PUT;
                     end
                  end
                  obd_pkg::PID_RPM: begin
                     if (cnt_ff >= obd_pkg::SLOT_W'(4)) begin
                        res_kind_in  = obd_pkg::KIND_RPM;
                        res_value_in = {1'b0, mb_ff[2], mb_ff[3][7:2]};
                        state_in     = obd_pkg::ST_PUT;
                     end
                  end
                  obd_pkg::PID_THROTTLE: begin
                     if (cnt_ff >= obd_pkg::SLOT_W'(3)) begin
                        state_in = obd_pkg::ST_THR_MUL;
                     end
                  end
                  obd_pkg::PID_COOLANT: begin
                     if (cnt_ff >= obd_pkg::SLOT_W'(3)) begin
                        res_kind_in  = obd_pkg::KIND_COOLANT;
                        res_value_in = VW'(mb_ff[2]) - VW'(obd_pkg::COOLANT_OFFSET);
                        state_in     = obd_pkg::ST_PUT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         obd_pkg::ST_THR_MUL: begin
            acc_in   = obd_pkg::PROD_W'(mb_ff[2]) *
                       obd_pkg::PROD_W'(obd_pkg::THROTTLE_SCALE);
            state_in = obd_pkg::ST_THR_EST;
         end

         obd_pkg::ST_THR_EST: begin
            // estimate is the exact quotient or one below it
            est      = obd_pkg::EST_W'(acc_ff) * obd_pkg::EST_W'(obd_pkg::THR_RECIP);
            q_in     = VW'(est >> obd_pkg::THR_SHIFT);
            state_in = obd_pkg::ST_THR_FIX;
         end

         obd_pkg::ST_THR_FIX: begin
            rem = obd_pkg::REM_W'(acc_ff) -
                  obd_pkg::REM_W'(q_ff) * obd_pkg::REM_W'(obd_pkg::THR_DIVISOR);
            res_kind_in  = obd_pkg::KIND_THROTTLE;
            res_value_in = (rem >= obd_pkg::REM_W'(obd_pkg::THR_DIVISOR)) ?
                           q_ff + 1'b1 : q_ff;
            state_in     = obd_pkg::ST_PUT;
         end

         obd_pkg::ST_PUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = res_kind_ff;
               out_value_in = res_value_ff;
               out_index_in = '0;
               out_char_in  = '0;
               out_last_in  = 1'b1;
               state_in     = obd_pkg::ST_IDLE;
            end
         end

         obd_pkg::ST_VIN_RD: begin
            state_in = obd_pkg::ST_VIN_PUT;
         end

         obd_pkg::ST_VIN_PUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = obd_pkg::KIND_VIN;
               out_value_in = '0;
               out_index_in = vk_ff;
               out_char_in  = vin_rd;
               out_last_in  = (vk_ff == obd_pkg::VIN_AW'(obd_pkg::VIN_LEN - 1));
               if (vk_ff == obd_pkg::VIN_AW'(obd_pkg::VIN_LEN - 1)) begin
                  state_in = obd_pkg::ST_IDLE;
               end else begin
                  vk_in    = vk_ff + 1'b1;
                  state_in = obd_pkg::ST_VIN_RD;
               end
            end
         end

         default: begin
            state_in = obd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= obd_pkg::ST_IDLE;
         len_ff       <= '0;
         dig_ff       <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         vcnt_ff      <= '0;
         vdone_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         dig_ff       <= dig_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         vcnt_ff      <= vcnt_in;
         vdone_ff     <= vdone_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nib_ff       <= nib_in;
      cnt_ff       <= cnt_in;
      rdidx_ff     <= rdidx_in;
      pidx_ff      <= pidx_in;
      prev_ff      <= prev_in;
      mb_ff        <= mb_in;
      vk_ff        <= vk_in;
      acc_ff       <= acc_in;
      q_ff         <= q_in;
      res_kind_ff  <= res_kind_in;
      res_value_ff <= res_value_in;
      out_kind_ff  <= out_kind_in;
      out_value_ff <= out_value_in;
      out_index_ff <= out_index_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_char_ff, out_index_ff, out_value_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== sv/obd_ram.sv =====
module obd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/sv/tb_obd_response_line_decoder.sv =====
module tb_obd_response_line_decoder;
   import obd_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int IDX_W         = 5;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 200;
   localparam int MAX_REPORTS   = 50;
   localparam string VIN_SYMBOLS = "0123456789ABCDEFGHJKLMNPRSTUVWXYZabcdwxyz";

   typedef struct {
      kind_type              kind;
      logic [VALUE_W-1:0]    value;
      logic [IDX_W-1:0]      vin_index;
      logic [BYTE_W-1:0]     vin_char;
      logic                  last;
   } reading_type;

   typedef logic [BYTE_W-1:0] byte_q_type [$];

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   // decoder image
   int unsigned       line_len;
   int unsigned       digit_cnt;
   logic [3:0]        high_nibble;
   logic [BYTE_W-1:0] pair_mem [LINE_SLOTS];
   logic [BYTE_W-1:0] vin_mem [VIN_LEN];
   int unsigned       vin_cnt;
   bit                vin_done;

   reading_type owed_readings [$];
   int unsigned owed_total = 0;
   int unsigned sent_items = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;

   int burst_left = 0;
   bit gaps_on = 1'b1;
   int hold_request = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int phase_left = 0;

   obd_response_line_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < MAX_REPORTS) begin
         $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
      end
      mismatches++;
   endtask

   function automatic int nibble_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      return -1;
   endfunction

   function automatic bit vin_symbol(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic void owe(input kind_type k, input int v, input int idx,
                               input logic [7:0] ch, input bit last);
      reading_type r;
      r.kind      = k;
      r.value     = VALUE_W'(v);
      r.vin_index = IDX_W'(idx);
      r.vin_char  = ch;
      r.last      = last;
      owed_readings.push_back(r);
      owed_total++;
   endfunction

   function automatic void close_line();
      int unsigned pairs;
      logic [7:0] a;
      logic [7:0] b;
      if (digit_cnt < MIN_DIGITS || digit_cnt % 2 != 0) return;
      pairs = digit_cnt / 2;
      for (int unsigned i = 0; i + 1 < pairs; i++) begin
         if (pair_mem[i] == MODE09_RSP && pair_mem[i+1] == PID_VIN) begin
            // a finished VIN swallows the line, no metric parse
            if (vin_done) return;
            for (int unsigned j = i + 2; j < pairs && vin_cnt < VIN_LEN; j++) begin
               if (vin_symbol(pair_mem[j])) begin
                  vin_mem[vin_cnt] = pair_mem[j];
                  vin_cnt++;
               end
            end
            if (vin_cnt >= VIN_LEN) begin
               vin_done = 1'b1;
               for (int k = 0; k < VIN_LEN; k++) begin
                  owe(KIND_VIN, 0, k, vin_mem[k], k == VIN_LEN - 1);
               end
            end
            return;
         end
      end
      if (pair_mem[0] != MODE01_RSP) return;
      a = pair_mem[2];
      b = pair_mem[3];
      case (pair_mem[1])
         PID_SPEED: begin
            if (pairs >= 3) owe(KIND_SPEED, int'(a), 0, 8'h00, 1'b1);
         end
         PID_RPM: begin
            if (pairs >= 4) owe(KIND_RPM, int'({a, b}) >> 2, 0, 8'h00, 1'b1);
         end
         PID_THROTTLE: begin
            if (pairs >= 3) owe(KIND_THROTTLE, int'(a) * 10000 / 255, 0, 8'h00, 1'b1);
         end
         PID_COOLANT: begin
            if (pairs >= 3) owe(KIND_COOLANT, int'(a) - 40, 0, 8'h00, 1'b1);
         end
         default: ;
      endcase
   endfunction

   function automatic void decode_char(input logic [1:0] act, input logic [7:0] c);
      int d;
      if (act == ACT_DROP || act == ACT_NEW_LINK) begin
         line_len  = 0;
         digit_cnt = 0;
         if (act == ACT_NEW_LINK) begin
            vin_cnt  = 0;
            vin_done = 1'b0;
         end
         return;
      end
      if (act != ACT_BYTE) return;
      if (c == CHAR_CR || c == CHAR_LF || c == CHAR_PROMPT) begin
         if (line_len != 0) close_line();
         line_len  = 0;
         digit_cnt = 0;
         return;
      end
      // overlong line: drop this character and start over
      if (line_len >= LINE_CHARS - 1) begin
         line_len  = 0;
         digit_cnt = 0;
         return;
      end
      line_len++;
      d = nibble_of(c);
      if (d >= 0 && digit_cnt < HEX_DIGITS - 1) begin
         if (digit_cnt % 2 == 0) begin
            high_nibble = d[3:0];
         end else begin
            pair_mem[digit_cnt / 2] = {high_nibble, d[3:0]};
         end
         digit_cnt++;
      end
   endfunction

   // result beats
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_readings.size() == 0) begin
            report_mismatch("beat with no reading owed", rsp_tdata, 32'h0);
         end else begin
            want = owed_readings.pop_front();
            if (rsp_tuser !== want.kind)
               report_mismatch("kind", 32'(rsp_tuser), 32'(want.kind));
            if (rsp_tdata[14:0] !== want.value)
               report_mismatch("value", 32'(rsp_tdata[14:0]), 32'(want.value));
            if (rsp_tdata[19:15] !== want.vin_index)
               report_mismatch("vin_index", 32'(rsp_tdata[19:15]), 32'(want.vin_index));
            if (rsp_tdata[27:20] !== want.vin_char)
               report_mismatch("vin_char", 32'(rsp_tdata[27:20]), 32'(want.vin_char));
            if (rsp_tlast !== want.last)
               report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
         end
      end
   end

   // rsp_tready: phases of full rate, half rate and heavy stall, plus long holds on request
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (phase_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         phase_left = $urandom_range(8, 64);
      end
      phase_left--;
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic push_char(input logic [1:0] act, input logic [7:0] ch);
      int idle;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         idle = gaps_on ? $urandom_range(0, 6) : 0;
         repeat (idle) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= ch;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_char(act, ch);
      if (act != ACT_UNUSED) sent_items++;
   endtask

   task automatic idle_req();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
   endtask

   task automatic wait_drain();
      int waited;
      idle_req();
      waited = 0;
      while (owed_readings.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   function automatic logic [7:0] pick_end();
      case ($urandom_range(0, 2))
         0: return CHAR_CR;
         1: return CHAR_LF;
         default: return CHAR_PROMPT;
      endcase
   endfunction

   function automatic string hex_text(input byte_q_type bytes, input bit lower,
                                      input bit spaced);
      string s;
      s = "";
      foreach (bytes[i]) begin
         s = {s, lower ? $sformatf("%02x", bytes[i]) : $sformatf("%02X", bytes[i])};
         if (spaced) s = {s, " "};
      end
      return s;
   endfunction

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(ACT_BYTE, s[i]);
   endtask

   task automatic send_line(input string s);
      send_text(s);
      push_char(ACT_BYTE, pick_end());
   endtask

   task automatic send_vin(input string vin, input int chunk);
      byte_q_type b;
      int pos;
      int seq;
      pos = 0;
      seq = 1;
      while (pos < vin.len()) begin
         b.delete();
         b.push_back(MODE09_RSP);
         b.push_back(PID_VIN);
         b.push_back(8'(seq));
         for (int i = 0; i < chunk && pos < vin.len(); i++) begin
            b.push_back(vin[pos]);
            pos++;
         end
         send_line(hex_text(b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
         seq++;
      end
   endtask

   function automatic logic [7:0] pick_data();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_pid();
      case ($urandom_range(0, 9))
         0, 1: return PID_SPEED;
         2, 3, 4: return PID_RPM;
         5, 6: return PID_THROTTLE;
         7, 8: return PID_COOLANT;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic test_metric_extremes();
      send_line("410D00");
      send_line("41 0D FF");
      send_line("410cffff");
      send_line("410C0000");
      send_line("4111FF");
      send_line("41 11 00");
      send_line("410500");
      send_line("4105ff");
   endtask

   task automatic test_malformed_lines();
      push_char(ACT_BYTE, CHAR_CR);
      send_line("41");
      send_line("410");
      send_line("410D0");
      send_line("410D");
      send_line("410C12");
      send_line("4142AA");
      send_line("420D10");
      // zero and high-bit characters are plain text inside a line
      send_text("41");
      push_char(ACT_BYTE, 8'h00);
      send_text("0D");
      push_char(ACT_BYTE, 8'hFF);
      push_char(ACT_BYTE, 8'h80);
      send_line("7a");
      send_line("NO DATA");
   endtask

   task automatic test_line_actions();
      send_text("410D");
      push_char(ACT_DROP, 8'h00);
      send_line("410D22");
      send_text("410D");
      push_char(ACT_UNUSED, 8'hFF);
      send_line("33");
      send_text("4105");
      push_char(ACT_NEW_LINK, 8'h5A);
      send_line("4105C8");
   endtask

   task automatic test_vin_collection();
      push_char(ACT_NEW_LINK, 8'h00);
      send_vin("1M8GDM9AXKP042788", VIN_LEN);
      send_line("4902013132");
      send_line("410D4902");
      send_line("410D3C");
      push_char(ACT_NEW_LINK, 8'h00);
      send_vin("WVWZZZ1JZXW000001", 5);
   endtask

   task automatic test_long_line();
      string pad;
      pad = "410D05";
      while (pad.len() < LINE_CHARS - 1) pad = {pad, " "};
      send_line(pad);
      // one character too many: the line restarts and its content is lost
      send_text(pad);
      push_char(ACT_BYTE, "x");
      send_line("410D06");
   endtask

   task automatic test_excess_digits();
      string s;
      s = "410D11";
      while (s.len() < HEX_DIGITS - 2) s = {s, "0"};
      send_line(s);
      send_line({s, "0"});
      send_line({s, "0123456789abcdef0123456789ABCDEF0123456789"});
   endtask

   task automatic test_backpressure();
      wait_drain();
      // hold rsp off long enough for the VIN beats to back up into the input
      hold_request = 400;
      gaps_on = 1'b0;
      push_char(ACT_NEW_LINK, 8'h00);
      send_vin("JH4KA7561PC008269", VIN_LEN);
      for (int i = 0; i < 6; i++) send_line($sformatf("410D%02X", i * 40));
      gaps_on = 1'b1;
   endtask

   task automatic send_random_metric();
      byte_q_type b;
      logic [7:0] pid;
      int need;
      int n;
      pid = pick_pid();
      need = (pid == PID_RPM) ? 2 : 1;
      if ($urandom_range(0, 7) == 0) begin
         n = $urandom_range(0, need);
      end else begin
         n = need + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      end
      b.push_back(MODE01_RSP);
      b.push_back(pid);
      repeat (n) b.push_back(pick_data());
      send_line(hex_text(b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
   endtask

   task automatic send_random_vin();
      byte_q_type b;
      int n;
      if (vin_done && $urandom_range(0, 1)) push_char(ACT_NEW_LINK, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) b.push_back(8'($urandom_range(0, 63)));
      end
      b.push_back(MODE09_RSP);
      b.push_back(PID_VIN);
      b.push_back(8'($urandom_range(1, 5)));
      n = $urandom_range(3, 10);
      repeat (n) begin
         if ($urandom_range(0, 7) == 0) begin
            b.push_back(8'($urandom_range(0, 255)));
         end else begin
            b.push_back(VIN_SYMBOLS[$urandom_range(0, VIN_SYMBOLS.len() - 1)]);
         end
      end
      send_line(hex_text(b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
   endtask

   task automatic send_noise();
      repeat ($urandom_range(0, 12)) push_char(ACT_BYTE, 8'($urandom_range(0, 255)));
      push_char(ACT_BYTE, pick_end());
   endtask

   task automatic send_broken();
      string s;
      int cut;
      logic [1:0] act;
      s = $sformatf("41%02X%02X%02X", pick_pid(), pick_data(), pick_data());
      cut = $urandom_range(0, s.len() - 1);
      case ($urandom_range(0, 2))
         0: act = ACT_DROP;
         1: act = ACT_NEW_LINK;
         default: act = ACT_UNUSED;
      endcase
      for (int i = 0; i < s.len(); i++) begin
         if (i == cut) push_char(act, 8'($urandom_range(0, 255)));
         push_char(ACT_BYTE, s[i]);
      end
      push_char(ACT_BYTE, pick_end());
   endtask

   task automatic test_random_traffic();
      int unsigned first_item;
      int unsigned first_owed;
      int unsigned lines;
      int pick;
      first_item = sent_items;
      first_owed = owed_total;
      lines = 0;
      while ((sent_items - first_item < 150 || owed_total - first_owed < 48) && lines < 800) begin
         gaps_on = ($urandom_range(0, 4) != 0);
         pick = $urandom_range(0, 19);
         if (pick <= 10) begin
            send_random_metric();
         end else if (pick <= 13) begin
            send_random_vin();
         end else if (pick <= 15) begin
            send_noise();
         end else if (pick <= 17) begin
            send_broken();
         end else if (pick == 18) begin
            send_line("SEARCHING...");
         end else begin
            push_char(ACT_DROP, 8'($urandom_range(0, 255)));
         end
         lines++;
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      line_len    = 0;
      digit_cnt   = 0;
      high_nibble = '0;
      vin_cnt     = 0;
      vin_done    = 1'b0;
      foreach (pair_mem[i]) pair_mem[i] = '0;
      foreach (vin_mem[i]) vin_mem[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_metric_extremes();
      test_malformed_lines();
      test_line_actions();
      test_vin_collection();
      test_long_line();
      test_excess_digits();
      test_backpressure();
      test_random_traffic();

      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (owed_readings.size() != 0) begin
         report_mismatch("readings never delivered", owed_readings.size(), 32'h0);
      end
      if (mismatches == 0) begin
         $display("** obd_response_line_decoder: PASSED **");
      end else begin
         $display("** obd_response_line_decoder: FAILED **");
      end
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** obd_response_line_decoder: FAILED **");
      $finish;
   end

endmodule
